@@ rtl/core/tld_pkg.sv @@
// Types, constants and sequencing functions of the terminal line discipline.
// Shared by tld_ctrl, tld_dpath and terminal_line_discipline_top; depends on nothing.
package tld_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_BS = 8'h08;

    localparam logic STREAM_SCREEN = 1'b0;
    localparam logic STREAM_LINE   = 1'b1;

    typedef enum logic [1:0] {
        REG_ECHO      = 2'd0,
        REG_CANONICAL = 2'd1,
        REG_POST_PROC = 2'd2,
        REG_CR_TO_CRLF = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ECHO,
        S_ECHO_LF,
        S_RAW_CR,
        S_RAW_LF,
        S_RAW_BYTE,
        S_EOL_CR,
        S_EOL_LF,
        S_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        SEL_SCREEN_BYTE,
        SEL_SCREEN_CR,
        SEL_SCREEN_LF,
        SEL_LINE_CR,
        SEL_LINE_LF,
        SEL_LINE_BYTE,
        SEL_LINE_STORE
    } sel_t;

    // Decoded view of one word: what it will produce.
    typedef struct packed {
        logic echo;
        logic post_proc;
        logic is_lf;
        logic is_cr;
        logic raw;
        logic cr_to_crlf;
        logic flush;
    } ctx_t;

    typedef struct packed {
        logic accept;
        logic emit;
        sel_t sel;
        logic last;
        logic rd_first;
        logic rd_next;
    } cmd_t;

    typedef struct packed {
        logic out_space;
        logic line_more;
        ctx_t in_ctx;
        ctx_t cur_ctx;
    } status_t;

    function automatic state_t after_echo(input ctx_t c);
        state_t s;
        if (c.raw) begin
            if (c.is_cr) begin
                s = c.cr_to_crlf ? S_RAW_CR : S_RAW_LF;
            end else begin
                s = S_RAW_BYTE;
            end
        end else if (c.flush) begin
            s = S_EOL_CR;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    function automatic state_t first_step(input ctx_t c);
        return c.echo ? S_ECHO : after_echo(c);
    endfunction

    function automatic state_t step_after(input state_t st, input ctx_t c, input logic more);
        state_t s;
        case (st)
            S_ECHO:     s = (c.post_proc && c.is_lf) ? S_ECHO_LF : after_echo(c);
            S_ECHO_LF:  s = after_echo(c);
            S_RAW_CR:   s = S_RAW_LF;
            S_RAW_LF:   s = S_IDLE;
            S_RAW_BYTE: s = S_IDLE;
            S_EOL_CR:   s = S_EOL_LF;
            S_EOL_LF:   s = S_FLUSH;
            S_FLUSH:    s = more ? S_FLUSH : S_IDLE;
            default:    s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/tld_ctrl.sv @@
// Sequencing state machine of the terminal line discipline.
// Depends on tld_pkg; drives the command struct of tld_dpath from its status struct.
module tld_ctrl
    import tld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    state_t step_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        step_next = step_after(state_reg, status.cur_ctx, status.line_more);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    state_next = first_step(status.in_ctx);
                end
            end
            default:
            begin
                if (status.out_space) begin
                    state_next = step_next;
                end
            end
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        cmd.accept   = (state_reg == S_IDLE) && in_valid;
        cmd.emit     = (state_reg != S_IDLE) && status.out_space;
        cmd.last     = (step_next == S_IDLE);
        cmd.rd_first = cmd.emit && (state_reg == S_EOL_LF);
        cmd.rd_next  = cmd.emit && (state_reg == S_FLUSH);
        case (state_reg)
            S_ECHO:
            begin
                cmd.sel = (status.cur_ctx.post_proc && status.cur_ctx.is_lf)
                          ? SEL_SCREEN_CR : SEL_SCREEN_BYTE;
            end
            S_ECHO_LF:  cmd.sel = SEL_SCREEN_LF;
            S_RAW_CR:   cmd.sel = SEL_LINE_CR;
            S_RAW_LF:   cmd.sel = SEL_LINE_LF;
            S_RAW_BYTE: cmd.sel = SEL_LINE_BYTE;
            S_EOL_CR:   cmd.sel = SEL_SCREEN_CR;
            S_EOL_LF:   cmd.sel = SEL_SCREEN_LF;
            S_FLUSH:    cmd.sel = SEL_LINE_STORE;
            default:    cmd.sel = SEL_SCREEN_BYTE;
        endcase
    end

`ifndef SYNTHESIS
    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |=> state_reg == S_IDLE)
        else $error("final word of an item did not return the sequencer to idle");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && !status.out_space |=> state_reg == $past(state_reg))
        else $error("sequencer advanced while the output register was full");
`endif

endmodule

@@ rtl/core/tld_dpath.sv @@
// Datapath of the terminal line discipline: registers, line store, output register.
// Depends on tld_pkg; commanded by tld_ctrl.
module tld_dpath
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        operation,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_stream,
    output logic [7:0]  out_byte,
    output logic        out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    input  cmd_t        cmd,
    output status_t     status
);

    localparam int CNT_W = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W = $clog2(LINE_DEPTH);

    logic echo_reg;
    logic canon_reg;
    logic post_proc_reg;
    logic cr_to_crlf_reg;

    logic [7:0]       line_mem [LINE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] flush_len_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] rd_nxt;
    logic [IDX_W-1:0] rd_addr;

    logic [7:0] byte_reg;
    ctx_t       ctx_reg;
    ctx_t       in_ctx;

    logic       out_valid_reg;
    logic       out_stream_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_space;

    logic       cfg_write;
    reg_index_t cfg_index;
    logic       is_bs;
    logic       do_backspace;
    logic       do_store;
    logic [7:0] emit_byte;
    logic       emit_stream;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg       <= 1'b1;
            canon_reg      <= 1'b1;
            post_proc_reg  <= 1'b1;
            cr_to_crlf_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ECHO:       echo_reg       <= pwdata[0];
                REG_CANONICAL:  canon_reg      <= pwdata[0];
                REG_POST_PROC:  post_proc_reg  <= pwdata[0];
                REG_CR_TO_CRLF: cr_to_crlf_reg <= pwdata[0];
                default:        echo_reg       <= echo_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ECHO:       prdata = {31'd0, echo_reg};
            REG_CANONICAL:  prdata = {31'd0, canon_reg};
            REG_POST_PROC:  prdata = {31'd0, post_proc_reg};
            REG_CR_TO_CRLF: prdata = {31'd0, cr_to_crlf_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        is_bs             = (in_byte == CH_BS);
        do_backspace      = !operation && canon_reg && is_bs && (count_reg != '0);
        in_ctx.echo       = operation || echo_reg;
        in_ctx.post_proc  = post_proc_reg;
        in_ctx.is_lf      = (in_byte == CH_LF);
        in_ctx.is_cr      = (in_byte == CH_CR);
        in_ctx.raw        = !operation && !canon_reg;
        in_ctx.cr_to_crlf = cr_to_crlf_reg;
        in_ctx.flush      = !operation && canon_reg && !do_backspace
                            && (in_ctx.is_cr || count_reg >= CNT_W'(LINE_DEPTH - 1));
        do_store          = !operation && canon_reg && !do_backspace;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
            ctx_reg  <= in_ctx;
        end
    end

    // Line store: written at accept time, read one entry per flushed word.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && do_store)
        begin
            line_mem[count_reg[IDX_W-1:0]] <= in_ctx.flush ? CH_LF : in_byte;
        end
        if (cmd.rd_first || cmd.rd_next)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_nxt  = CNT_W'(rd_idx_reg) + CNT_W'(1);
    assign rd_addr = cmd.rd_first ? '0 : rd_nxt[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            flush_len_reg <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.accept && do_backspace)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            else if (cmd.accept && do_store && in_ctx.flush)
            begin
                flush_len_reg <= count_reg + CNT_W'(1);
                count_reg     <= '0;
            end
            else if (cmd.accept && do_store)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.rd_first || cmd.rd_next)
            begin
                rd_idx_reg <= rd_addr;
            end
        end
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_SCREEN_BYTE:
            begin
                emit_stream = STREAM_SCREEN;
                emit_byte   = byte_reg;
            end
            SEL_SCREEN_CR:
            begin
                emit_stream = STREAM_SCREEN;
                emit_byte   = CH_CR;
            end
            SEL_SCREEN_LF:
            begin
                emit_stream = STREAM_SCREEN;
                emit_byte   = CH_LF;
            end
            SEL_LINE_CR:
            begin
                emit_stream = STREAM_LINE;
                emit_byte   = CH_CR;
            end
            SEL_LINE_LF:
            begin
                emit_stream = STREAM_LINE;
                emit_byte   = CH_LF;
            end
            SEL_LINE_BYTE:
            begin
                emit_stream = STREAM_LINE;
                emit_byte   = byte_reg;
            end
            SEL_LINE_STORE:
            begin
                emit_stream = STREAM_LINE;
                emit_byte   = rd_data_reg;
            end
            default:
            begin
                emit_stream = STREAM_SCREEN;
                emit_byte   = byte_reg;
            end
        endcase
    end

    assign out_space = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_stream_reg <= emit_stream;
            out_byte_reg   <= emit_byte;
            out_last_reg   <= cmd.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_stream = out_stream_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;

    always_comb
    begin
        status.out_space = out_space;
        status.line_more = (rd_nxt < flush_len_reg);
        status.in_ctx    = in_ctx;
        status.cur_ctx   = ctx_reg;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(LINE_DEPTH))
        else $error("line count reached the store depth");

    a_read_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_next |-> CNT_W'(rd_idx_reg) < flush_len_reg)
        else $error("flush read past the end of the collected line");
`endif

endmodule

@@ rtl/core/terminal_line_discipline_top.sv @@
// Top level of the terminal line discipline: controller plus datapath.
// Depends on tld_pkg, tld_ctrl and tld_dpath.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid, in_stall   operation, in_byte, in_last
//   output   out        out_valid, out_stall out_stream, out_byte, out_last
//   config   in         APB psel/penable     paddr, pwdata, prdata (pready high)
//
// A word is taken while the sequencer is idle; each result word is then emitted when
// the output register is free, and a line flush is paced by one store read per word.
// Reset clears the registers to their defaults and empties the line.
// A stall on the output holds the sequencer; the input is stalled until it is idle.
module terminal_line_discipline_top
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_stream,
    output logic [7:0]  out_byte,
    output logic        out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    tld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tld_dpath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (operation),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_stream (out_stream),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

@@ test/line_discipline_checker.sv @@
// Checker for the terminal line discipline: follows the input, output and register
// channels, predicts the result words and compares them. Depends on tld_pkg only.
module line_discipline_checker
    import tld_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        out_stream,
    input  logic [7:0]  out_byte,
    input  logic        out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending,
    output int          checked,
    output int          flushes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       stream;
        logic [7:0] data;
        logic       last;
    } out_word_t;

    out_word_t  expected_words[$];
    logic [7:0] held_line[LINE_DEPTH];
    int         line_len;
    logic       echo_on;
    logic       canon_on;
    logic       post_on;
    logic       crlf_on;

    task automatic emit(input logic stream, input logic [7:0] data);
        expected_words.push_back('{stream: stream, data: data, last: 1'b0});
    endtask

    task automatic to_screen(input logic [7:0] data);
        if (post_on && data == CH_LF)
        begin
            emit(STREAM_SCREEN, CH_CR);
            emit(STREAM_SCREEN, CH_LF);
        end
        else
        begin
            emit(STREAM_SCREEN, data);
        end
    endtask

    task automatic keep(input logic [7:0] data);
        if (line_len < LINE_DEPTH)
        begin
            held_line[line_len] = data;
            line_len++;
        end
    endtask

    task automatic apply_line_rules(input logic op, input logic [7:0] data);
        int        base;
        out_word_t tail;
        base = expected_words.size();
        if (op)
        begin
            to_screen(data);
        end
        else
        begin
            if (echo_on)
                to_screen(data);
            if (!canon_on)
            begin
                if (data == CH_CR)
                begin
                    if (crlf_on)
                        emit(STREAM_LINE, CH_CR);
                    emit(STREAM_LINE, CH_LF);
                end
                else
                begin
                    emit(STREAM_LINE, data);
                end
            end
            else if (data == CH_BS && line_len > 0)
            begin
                line_len--;
            end
            else if (data == CH_CR || line_len >= LINE_DEPTH - 1)
            begin
                keep(CH_LF);
                emit(STREAM_SCREEN, CH_CR);
                emit(STREAM_SCREEN, CH_LF);
                for (int i = 0; i < line_len; i++)
                    emit(STREAM_LINE, held_line[i]);
                line_len = 0;
                flushes++;
            end
            else
            begin
                keep(data);
            end
        end
        if (expected_words.size() > base)
        begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            line_len = 0;
            echo_on  = 1'b1;
            canon_on = 1'b1;
            post_on  = 1'b1;
            crlf_on  = 1'b0;
            errors   = 0;
            checked  = 0;
            flushes  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_ECHO:       echo_on  = pwdata[0];
                    REG_CANONICAL:  canon_on = pwdata[0];
                    REG_POST_PROC:  post_on  = pwdata[0];
                    REG_CR_TO_CRLF: crlf_on  = pwdata[0];
                    default:        ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: out_stream %0d out_byte 0x%02h out_last %0d",
                           out_stream, out_byte, out_last);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    checked++;
                    if (out_stream !== want.stream)
                    begin
                        $error("out_stream mismatch: expected %0d, got %0d",
                               want.stream, out_stream);
                        errors++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte mismatch: expected 0x%02h, got 0x%02h",
                               want.data, out_byte);
                        errors++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last mismatch: expected %0d, got %0d",
                               want.last, out_last);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_line_rules(operation, in_byte);
        end
        pending = expected_words.size();
    end

endmodule

@@ test/testbench.sv @@
// Top of the terminal line discipline testbench: clock, reset, stimulus and verdict.
// Depends on tld_pkg, terminal_line_discipline_top and line_discipline_checker.
module testbench
    import tld_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH  = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 18;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        operation = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        in_last   = 1'b0;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = 4'h0;
    logic [31:0] pwdata    = 32'h0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stream;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int checked;
    int flushes;
    int typed_sent   = 0;
    int program_sent = 0;
    int settings     = 0;
    bit quiet        = 1'b0;
    bit hold_req     = 1'b0;

    terminal_line_discipline_top #(.LINE_DEPTH(LINE_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .in_byte(in_byte), .in_last(in_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_stream(out_stream), .out_byte(out_byte), .out_last(out_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    line_discipline_checker #(.LINE_DEPTH(LINE_DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .in_byte(in_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_stream(out_stream), .out_byte(out_byte), .out_last(out_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .errors(errors), .pending(pending), .checked(checked), .flushes(flushes)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[terminal_line_discipline_top] ERROR");
        $finish;
    end

    // The receiver stalls in short bursts, or for one long stretch when asked.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_word(input logic op, input logic [7:0] data);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            in_valid  = 1'b0;
            operation = 1'($urandom());
            in_byte   = 8'($urandom());
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        in_valid  = 1'b1;
        operation = op;
        in_byte   = data;
        in_last   = 1'($urandom());
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op)
            program_sent++;
        else
            typed_sent++;
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (LINE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {31'($urandom()), value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_mode(input logic echo, input logic canon, input logic post,
                            input logic crlf);
        wait_idle();
        write_reg(REG_ECHO, echo);
        write_reg(REG_CANONICAL, canon);
        write_reg(REG_POST_PROC, post);
        write_reg(REG_CR_TO_CRLF, crlf);
        settings++;
    endtask

    function automatic logic [7:0] line_char();
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            c = CH_BS;
        else if (pick == 1)
            c = CH_LF;
        else if (pick inside {[2:6]})
            c = 8'($urandom_range(8'h20, 8'h7E));
        else
            c = 8'($urandom());
        return c;
    endfunction

    initial
    begin : stimulus
        int         start;
        int         len;
        logic [3:0] mode;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        set_mode(1'b1, 1'b1, 1'b1, 1'b0);
        send_word(1'b1, CH_LF);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hFF);
        send_word(1'b1, CH_CR);
        send_word(1'b0, CH_BS);
        send_word(1'b0, 8'h61);
        send_word(1'b0, CH_BS);
        send_word(1'b0, CH_LF);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, CH_CR);

        set_mode(1'b1, 1'b0, 1'b0, 1'b0);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_LF);
        send_word(1'b0, 8'h78);
        send_word(1'b1, CH_LF);

        set_mode(1'b0, 1'b0, 1'b1, 1'b1);
        send_word(1'b0, CH_CR);
        send_word(1'b0, CH_BS);
        send_word(1'b0, 8'h80);

        set_mode(1'b0, 1'b1, 1'b1, 1'b1);
        send_word(1'b0, 8'h71);
        send_word(1'b0, CH_BS);
        send_word(1'b0, CH_CR);

        // A line longer than the store while the receiver holds off.
        set_mode(1'b1, 1'b1, 1'b1, 1'b0);
        hold_req = 1'b1;
        for (int i = 0; i < LINE_DEPTH + 8; i++)
            send_word(1'b0, 8'($urandom_range(8'h21, 8'h7E)));
        send_word(1'b0, CH_CR);
        wait_results();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                mode = 4'b0000;
            else if (p == 1)
                mode = 4'b1111;
            else
                mode = 4'($urandom_range(0, 15));
            set_mode(mode[0], mode[1], mode[2], mode[3]);
            quiet = (p == PHASES - 1);
            start = typed_sent + program_sent;
            while (typed_sent + program_sent - start < PHASE_WORDS)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 40)
                                                      : $urandom_range(0, 12);
                    for (int j = 0; j < len; j++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_word(1'b1, line_char());
                        send_word(1'b0, line_char());
                    end
                    send_word(1'b0, CH_CR);
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(1'($urandom()), 8'($urandom()));
                end
                if (!quiet && $urandom_range(0, 7) == 0)
                    wait_results();
            end
        end

        wait_idle();
        $display("Sent %0d typed and %0d program output words under %0d register settings.",
                 typed_sent, program_sent, settings);
        $display("Checked %0d result words, including %0d delivered lines.",
                 checked, flushes);
        if (errors == 0 && pending == 0)
        begin
            $display("[terminal_line_discipline_top] OK");
        end
        else
        begin
            $display("[terminal_line_discipline_top] ERROR");
        end
        $finish;
    end

endmodule

@@ terminal_line_discipline_top.f @@
rtl/core/tld_pkg.sv
rtl/core/tld_ctrl.sv
rtl/core/tld_dpath.sv
rtl/core/terminal_line_discipline_top.sv
test/line_discipline_checker.sv
test/testbench.sv
